// File: rtl/sia_pkg.sv
// Shared types and constants for the saturating interval ALU.
package sia_pkg;

    localparam int FIELD_W = 63;    // width of every bound field on the ports
    localparam int LATENCY = 5;     // cycles from accept to result strobe

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_SUB   = 2'd1,
        CMD_MUL   = 2'd2,
        CMD_ISECT = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd               command;
        logic [FIELD_W-1:0] left_min;
        logic [FIELD_W-1:0] left_max;
        logic [FIELD_W-1:0] right_min;
        logic [FIELD_W-1:0] right_max;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0] result_min;
        logic [FIELD_W-1:0] result_max;
        logic               result_empty;
        logic               intervals_equal;
        logic               left_contains_right;
    } t_out_item;

    // control that rides along with an item between pipeline modules
    typedef struct packed {
        logic valid;
        t_cmd command;
    } t_ctl;

endpackage

// File: rtl/sia_canon.sv
// Input stage: canonicalizes both operand intervals and registers them.
module sia_canon #(
    parameter int W = 63
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  sia_pkg::t_in_item   i_item,
    output sia_pkg::t_ctl       o_ctl,
    output logic [W-1:0]        o_lmin,
    output logic [W-1:0]        o_lmax,
    output logic [W-1:0]        o_rmin,
    output logic [W-1:0]        o_rmax
);

    localparam logic [W-1:0] TOP = {W{1'b1}};

    sia_pkg::t_ctl r_ctl;
    logic [W-1:0]  r_lmin, r_lmax, r_rmin, r_rmax;
    logic [W-1:0]  n_lmin, n_lmax, n_rmin, n_rmax;

    // raw compare first, then clip each bound to TOP
    function automatic logic [W-1:0] f_clip(input logic [sia_pkg::FIELD_W-1:0] v);
        logic [sia_pkg::FIELD_W:0] ext;
        ext = {1'b0, v};
        return (|ext[sia_pkg::FIELD_W:W]) ? TOP : ext[W-1:0];
    endfunction

    always_comb begin
        if (i_item.left_max < i_item.left_min) begin
            n_lmin = TOP;
            n_lmax = TOP;
        end else begin
            n_lmin = f_clip(i_item.left_min);
            n_lmax = f_clip(i_item.left_max);
        end
        if (i_item.right_max < i_item.right_min) begin
            n_rmin = TOP;
            n_rmax = TOP;
        end else begin
            n_rmin = f_clip(i_item.right_min);
            n_rmax = f_clip(i_item.right_max);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= i_valid;
        end
        r_ctl.command <= i_item.command;
        r_lmin        <= n_lmin;
        r_lmax        <= n_lmax;
        r_rmin        <= n_rmin;
        r_rmax        <= n_rmax;
    end

    assign o_ctl  = r_ctl;
    assign o_lmin = r_lmin;
    assign o_lmax = r_lmax;
    assign o_rmin = r_rmin;
    assign o_rmax = r_rmax;

endmodule

// File: rtl/sia_mul.sv
// Three-stage saturating multiplier built from four half-width partial products.
module sia_mul #(
    parameter int W = 63
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic [W-1:0] o_p
);

    localparam int Half = (W + 1) / 2;

    logic [2*Half-1:0] ax, bx;
    logic [2*Half-1:0] r_ll, r_lh, r_hl, r_hh;
    logic [2*Half-1:0] r_ll2, r_hh2;
    logic [2*Half:0]   r_mid;
    logic [4*Half-1:0] prod;
    logic              ovf;
    logic [W-1:0]      r_p;

    assign ax = (2*Half)'(i_a);
    assign bx = (2*Half)'(i_b);

    // low and high halves do not overlap, so they concatenate
    assign prod = {r_hh2, r_ll2} + ((4*Half)'(r_mid) << Half);
    assign ovf  = |prod[4*Half-1:W];

    always_ff @(posedge i_clk) begin
        r_ll  <= ax[Half-1:0]      * bx[Half-1:0];
        r_lh  <= ax[Half-1:0]      * bx[2*Half-1:Half];
        r_hl  <= ax[2*Half-1:Half] * bx[Half-1:0];
        r_hh  <= ax[2*Half-1:Half] * bx[2*Half-1:Half];
        r_mid <= {1'b0, r_lh} + {1'b0, r_hl};
        r_ll2 <= r_ll;
        r_hh2 <= r_hh;
        r_p   <= ovf ? {W{1'b1}} : prod[W-1:0];
    end

    assign o_p = r_p;

endmodule

// File: rtl/saturating_interval_alu.sv
// Top level of the saturating interval ALU: five-stage pipeline.
//
//  channel  | ports                  | handshake
//  ---------+------------------------+---------------------------------------
//  command  | start, busy, i_item    | item taken when start && !busy
//  result   | o_valid, o_item        | one-cycle strobe, no backpressure
//
// One item per cycle sustained.
// Stages: canonicalize, partial products / add / sub / intersect / flags,
// product middle sum, product combine and saturate, result select and
// canonicalize. The 63x63 multiply sets the depth.
// Reset (synchronous, active low) clears the valid bits only.
// busy is held low: the pipeline never stalls since results cannot be held off.
module saturating_interval_alu #(
    parameter int VALUE_BITS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  sia_pkg::t_in_item   i_item,
    output logic                o_valid,
    output sia_pkg::t_out_item  o_item
);

    localparam int W = VALUE_BITS - 1;
    localparam logic [W-1:0] TOP = {W{1'b1}};

    // stage 1 outputs
    sia_pkg::t_ctl s1_ctl;
    logic [W-1:0]  s1_lmin, s1_lmax, s1_rmin, s1_rmax;

    // stage 2..4 carried state
    sia_pkg::t_ctl r2_ctl, r3_ctl, r4_ctl;
    logic          r2_empty, r3_empty, r4_empty;   // any operand empty
    logic          r2_eq, r3_eq, r4_eq;
    logic          r2_cont, r3_cont, r4_cont;
    logic [W-1:0]  r2_lo, r2_hi, r3_lo, r3_hi, r4_lo, r4_hi;
    logic [W-1:0]  n2_lo, n2_hi;

    // multiplier outputs, aligned with stage 4
    logic [W-1:0]  mul_lo, mul_hi;

    // stage 5
    logic [W-1:0]  n5_lo, n5_hi, sel_lo, sel_hi;
    logic [W-1:0]  r5_lo, r5_hi;
    logic          r5_eq, r5_cont, r5_valid;

    function automatic logic [W-1:0] f_sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {1'b0, a} + {1'b0, b};
        // a TOP operand always carries or lands exactly on TOP
        return s[W] ? TOP : s[W-1:0];
    endfunction

    function automatic logic [W-1:0] f_sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (d[W] || (d[W-1:0] == '0)) begin
            return '0;
        end
        if (a == TOP) begin
            return TOP;
        end
        return d[W-1:0];
    endfunction

    assign busy = 1'b0;

    sia_canon #(
        .W (W)
    ) u_canon (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_item  (i_item),
        .o_ctl   (s1_ctl),
        .o_lmin  (s1_lmin),
        .o_lmax  (s1_lmax),
        .o_rmin  (s1_rmin),
        .o_rmax  (s1_rmax)
    );

    // bound-wise products, aligned with stage 4
    sia_mul #(
        .W (W)
    ) u_mul_lo (
        .i_clk (i_clk),
        .i_a   (s1_lmin),
        .i_b   (s1_rmin),
        .o_p   (mul_lo)
    );

    sia_mul #(
        .W (W)
    ) u_mul_hi (
        .i_clk (i_clk),
        .i_a   (s1_lmax),
        .i_b   (s1_rmax),
        .o_p   (mul_hi)
    );

    // stage 2: non-multiply ops
    always_comb begin
        n2_lo = '0;
        n2_hi = '0;
        unique case (s1_ctl.command)
            sia_pkg::CMD_ADD: begin
                n2_lo = f_sat_add(s1_lmin, s1_rmin);
                n2_hi = f_sat_add(s1_lmax, s1_rmax);
            end
            sia_pkg::CMD_SUB: begin
                n2_lo = f_sat_sub(s1_lmin, s1_rmax);
                n2_hi = f_sat_sub(s1_lmax, s1_rmin);
            end
            sia_pkg::CMD_ISECT: begin
                n2_lo = (s1_lmin > s1_rmin) ? s1_lmin : s1_rmin;
                n2_hi = (s1_lmax < s1_rmax) ? s1_lmax : s1_rmax;
            end
            default: begin
                n2_lo = '0;     // multiply comes from the multiplier units
                n2_hi = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl.valid <= 1'b0;
            r3_ctl.valid <= 1'b0;
            r4_ctl.valid <= 1'b0;
            r5_valid     <= 1'b0;
        end else begin
            r2_ctl.valid <= s1_ctl.valid;
            r3_ctl.valid <= r2_ctl.valid;
            r4_ctl.valid <= r3_ctl.valid;
            r5_valid     <= r4_ctl.valid;
        end
        r2_ctl.command <= s1_ctl.command;
        r2_empty       <= (s1_lmin == TOP) || (s1_rmin == TOP);
        r2_eq          <= (s1_lmin == s1_rmin) && (s1_lmax == s1_rmax);
        r2_cont        <= (s1_lmin <= s1_rmin) && (s1_rmin <= s1_lmax)
                       && (s1_lmin <= s1_rmax) && (s1_rmax <= s1_lmax);
        r2_lo          <= n2_lo;
        r2_hi          <= n2_hi;

        r3_ctl.command <= r2_ctl.command;
        r3_empty       <= r2_empty;
        r3_eq          <= r2_eq;
        r3_cont        <= r2_cont;
        r3_lo          <= r2_lo;
        r3_hi          <= r2_hi;

        r4_ctl.command <= r3_ctl.command;
        r4_empty       <= r3_empty;
        r4_eq          <= r3_eq;
        r4_cont        <= r3_cont;
        r4_lo          <= r3_lo;
        r4_hi          <= r3_hi;

        r5_lo          <= n5_lo;
        r5_hi          <= n5_hi;
        r5_eq          <= r4_eq;
        r5_cont        <= r4_cont;
    end

    // stage 5: pick the result, force empty, canonicalize
    always_comb begin
        if (r4_ctl.command == sia_pkg::CMD_MUL) begin
            sel_lo = mul_lo;
            sel_hi = mul_hi;
        end else begin
            sel_lo = r4_lo;
            sel_hi = r4_hi;
        end
        if (r4_empty && (r4_ctl.command != sia_pkg::CMD_ISECT)) begin
            n5_lo = TOP;
            n5_hi = TOP;
        end else if (sel_hi < sel_lo) begin
            n5_lo = TOP;
            n5_hi = TOP;
        end else begin
            n5_lo = sel_lo;
            n5_hi = sel_hi;
        end
    end

    assign o_valid                    = r5_valid;
    assign o_item.result_min          = (sia_pkg::FIELD_W)'(r5_lo);
    assign o_item.result_max          = (sia_pkg::FIELD_W)'(r5_hi);
    assign o_item.result_empty        = (r5_lo == TOP);
    assign o_item.intervals_equal     = r5_eq;
    assign o_item.left_contains_right = r5_cont;

endmodule

// File: rtl/sia_check.sv
// Port-level checker for the saturating interval ALU, bound to the top level.
module sia_check #(
    parameter int VALUE_BITS = 64
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input sia_pkg::t_out_item o_item,
    input logic               o_valid
);

    localparam int W = VALUE_BITS - 1;
    localparam logic [sia_pkg::FIELD_W-1:0] TOP_F = (sia_pkg::FIELD_W)'({W{1'b1}});

    a_valid_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, sia_pkg::LATENCY))
        else $error("result strobe without an accepted item");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_valid)
        else $error("accepted item produced no result");

    a_canonical: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.result_min <= o_item.result_max)
                 && (o_item.result_empty == (o_item.result_min == TOP_F)))
        else $error("result interval not canonical");

    a_equal_contains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.intervals_equal) |-> o_item.left_contains_right)
        else $error("equal intervals must contain each other");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

endmodule

bind saturating_interval_alu sia_check #(
    .VALUE_BITS (VALUE_BITS)
) u_sia_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_item  (o_item),
    .o_valid (o_valid)
);

// File: test/saturating_interval_alu_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the saturating interval ALU: directed corners, then random items.
module saturating_interval_alu_test;

    localparam int FIELD_W = sia_pkg::FIELD_W;
    localparam int LATENCY = sia_pkg::LATENCY;

    // Default VALUE_BITS = 64, so the top value is all ones in a bound field.
    localparam logic [FIELD_W-1:0] TOP = '1;
    localparam int DRAIN_CYCLES = LATENCY + 8;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 40;

    typedef struct packed {
        logic [FIELD_W-1:0] lo;
        logic [FIELD_W-1:0] hi;
    } t_span;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic               busy;
    sia_pkg::t_in_item  i_item  = '0;
    logic               o_valid;
    sia_pkg::t_out_item o_item;

    // Interval results still owed by the block, oldest first.
    sia_pkg::t_out_item pending_results[$];
    int        mismatch_count = 0;
    int        results_checked = 0;
    int        items_sent = 0;
    int        cmd_count[4] = '{0, 0, 0, 0};

    saturating_interval_alu DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Interval arithmetic predictor
    // ------------------------------------------------------------------

    // hi below lo (raw) collapses to the empty encoding; fields never exceed TOP here
    function automatic t_span canon(input logic [FIELD_W-1:0] lo, input logic [FIELD_W-1:0] hi);
        t_span s;
        if (hi < lo) begin
            s = '{lo: TOP, hi: TOP};
        end else begin
            s = '{lo: lo, hi: hi};
        end
        return s;
    endfunction

    function automatic logic [FIELD_W-1:0] bound_add(input logic [FIELD_W-1:0] a,
                                                     input logic [FIELD_W-1:0] b);
        logic [FIELD_W:0] sum;
        if (a == TOP || b == TOP) return TOP;
        sum = {1'b0, a} + {1'b0, b};
        return (sum > {1'b0, TOP}) ? TOP : sum[FIELD_W-1:0];
    endfunction

    // floors at zero; an unbounded minuend stays unbounded
    function automatic logic [FIELD_W-1:0] bound_sub(input logic [FIELD_W-1:0] a,
                                                     input logic [FIELD_W-1:0] b);
        if (a <= b) return '0;
        if (a == TOP) return TOP;
        return a - b;
    endfunction

    // zero wins over unbounded; full-width product tells overflow
    function automatic logic [FIELD_W-1:0] bound_mul(input logic [FIELD_W-1:0] a,
                                                     input logic [FIELD_W-1:0] b);
        logic [2*FIELD_W-1:0] prod;
        if (a == '0 || b == '0) return '0;
        if (a == TOP || b == TOP) return TOP;
        prod = {{FIELD_W{1'b0}}, a} * {{FIELD_W{1'b0}}, b};
        return (prod > {{FIELD_W{1'b0}}, TOP}) ? TOP : prod[FIELD_W-1:0];
    endfunction

    function automatic sia_pkg::t_out_item predict_interval_result(input sia_pkg::t_in_item it);
        t_span              l;
        t_span              r;
        t_span              res;
        logic               any_empty;
        sia_pkg::t_out_item out;
        l = canon(it.left_min, it.left_max);
        r = canon(it.right_min, it.right_max);
        any_empty = (l.lo == TOP) || (r.lo == TOP);
        case (it.command)
            sia_pkg::CMD_ADD: begin
                res = any_empty ? canon(TOP, TOP)
                                : canon(bound_add(l.lo, r.lo), bound_add(l.hi, r.hi));
            end
            sia_pkg::CMD_SUB: begin
                res = any_empty ? canon(TOP, TOP)
                                : canon(bound_sub(l.lo, r.hi), bound_sub(l.hi, r.lo));
            end
            sia_pkg::CMD_MUL: begin
                res = any_empty ? canon(TOP, TOP)
                                : canon(bound_mul(l.lo, r.lo), bound_mul(l.hi, r.hi));
            end
            default: begin
                // intersect has no empty shortcut: the encoding itself drives it
                res = canon((l.lo > r.lo) ? l.lo : r.lo, (l.hi < r.hi) ? l.hi : r.hi);
            end
        endcase
        out.result_min          = res.lo;
        out.result_max          = res.hi;
        out.result_empty        = (res.lo == TOP);
        out.intervals_equal     = (l.lo == r.lo) && (l.hi == r.hi);
        out.left_contains_right = (l.lo <= r.lo) && (r.lo <= l.hi) &&
                                  (l.lo <= r.hi) && (r.hi <= l.hi);
        return out;
    endfunction

    // ------------------------------------------------------------------
    // Random item generation
    // ------------------------------------------------------------------

    // magnitudes spread over all widths so products land on both sides of TOP
    function automatic logic [FIELD_W-1:0] random_bound();
        logic [63:0] raw;
        int          sel;
        raw = {$urandom, $urandom};
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return '0;
            1:       return TOP;
            2:       return TOP - FIELD_W'($urandom_range(0, 3));
            3:       return FIELD_W'($urandom_range(0, 15));
            default: return raw[FIELD_W-1:0] >> $urandom_range(0, FIELD_W - 1);
        endcase
    endfunction

    function automatic logic [FIELD_W-1:0] random_within(input logic [FIELD_W-1:0] lo,
                                                         input logic [FIELD_W-1:0] hi);
        logic [63:0] width;
        logic [63:0] raw;
        width = {1'b0, hi} - {1'b0, lo} + 64'd1;
        raw   = {$urandom, $urandom};
        return FIELD_W'({1'b0, lo} + raw % width);
    endfunction

    // mostly well-formed intervals; some inverted, empty, unbounded or single points
    function automatic t_span random_interval();
        t_span              s;
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        int                 mode;
        a = random_bound();
        b = random_bound();
        mode = $urandom_range(0, 99);
        if (mode < 65) begin
            s.lo = (a < b) ? a : b;
            s.hi = (a < b) ? b : a;
        end else if (mode < 77) begin
            s.lo = (a > b) ? a : b;
            s.hi = (a > b) ? b : a;
        end else if (mode < 83) begin
            s = '{lo: TOP, hi: TOP};
        end else if (mode < 91) begin
            s.lo = a;
            s.hi = TOP;
        end else begin
            s.lo = a;
            s.hi = a;
        end
        return s;
    endfunction

    // right side is sometimes a copy of the left or nested in it, to hit the flags
    function automatic sia_pkg::t_in_item random_item();
        sia_pkg::t_in_item it;
        t_span             l;
        t_span             r;
        int                mode;
        l = random_interval();
        mode = $urandom_range(0, 99);
        if (mode < 12) begin
            r = l;
        end else if (mode < 30 && l.lo <= l.hi) begin
            r.lo = random_within(l.lo, l.hi);
            r.hi = random_within(r.lo, l.hi);
        end else begin
            r = random_interval();
        end
        it.command   = sia_pkg::t_cmd'($urandom_range(0, 3));
        it.left_min  = l.lo;
        it.left_max  = l.hi;
        it.right_min = r.lo;
        it.right_max = r.hi;
        return it;
    endfunction

    function automatic sia_pkg::t_in_item mk(input sia_pkg::t_cmd c,
                                    input logic [FIELD_W-1:0] lmin, input logic [FIELD_W-1:0] lmax,
                                    input logic [FIELD_W-1:0] rmin, input logic [FIELD_W-1:0] rmax);
        sia_pkg::t_in_item it;
        it.command   = c;
        it.left_min  = lmin;
        it.left_max  = lmax;
        it.right_min = rmin;
        it.right_max = rmax;
        return it;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int next_gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Driving: inputs change on the falling edge
    // ------------------------------------------------------------------

    // start stays high if the next item follows with no gap
    task automatic send_item(input sia_pkg::t_in_item it);
        @(negedge i_clk);
        start  = 1'b1;
        i_item = it;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(predict_interval_result(it));
        items_sent++;
        cmd_count[it.command]++;
    endtask

    // idle cycles carry junk on the item bus; the block must ignore it
    task automatic idle_cycles(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            start  = 1'b0;
            i_item = random_item();
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Checking: outputs sampled on the rising edge
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] want,
                                   input logic [FIELD_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t ns: result %0d, %s: expected %h, got %h",
                     $time, results_checked, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        sia_pkg::t_out_item want;
        if (i_rst_n && $isunknown(o_valid)) begin
            report_mismatch("o_valid unknown", '0, '0);
        end else if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no item pending", '0, o_item.result_min);
            end else begin
                want = pending_results.pop_front();
                if (o_item.result_min !== want.result_min)
                    report_mismatch("result_min", want.result_min, o_item.result_min);
                if (o_item.result_max !== want.result_max)
                    report_mismatch("result_max", want.result_max, o_item.result_max);
                if (o_item.result_empty !== want.result_empty)
                    report_mismatch("result_empty", FIELD_W'(want.result_empty),
                                    FIELD_W'(o_item.result_empty));
                if (o_item.intervals_equal !== want.intervals_equal)
                    report_mismatch("intervals_equal", FIELD_W'(want.intervals_equal),
                                    FIELD_W'(o_item.intervals_equal));
                if (o_item.left_contains_right !== want.left_contains_right)
                    report_mismatch("left_contains_right", FIELD_W'(want.left_contains_right),
                                    FIELD_W'(o_item.left_contains_right));
            end
            results_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // corners of every command: saturation, flooring, zero factor, overflow edge,
    // empty and inverted operands, disjoint and nested intersections
    task automatic test_directed_cases();
        sia_pkg::t_in_item cases[$];
        cases.push_back(mk(sia_pkg::CMD_ADD, '0, '0, '0, '0));
        cases.push_back(mk(sia_pkg::CMD_ADD, TOP - 5, TOP - 1, 63'd3, 63'd10));  // saturates max
        cases.push_back(mk(sia_pkg::CMD_ADD, 63'd1, TOP, 63'd2, 63'd5));         // unbounded left
        cases.push_back(mk(sia_pkg::CMD_ADD, TOP, TOP, 63'd1, 63'd2));           // empty left
        cases.push_back(mk(sia_pkg::CMD_ADD, TOP, TOP, TOP, TOP));               // all ones
        cases.push_back(mk(sia_pkg::CMD_ADD, '0, TOP, TOP, TOP));       // empty right, contained
        cases.push_back(mk(sia_pkg::CMD_SUB, 63'd10, 63'd20, 63'd3, 63'd5));
        cases.push_back(mk(sia_pkg::CMD_SUB, 63'd1, 63'd2, 63'd5, 63'd9));       // floors at zero
        cases.push_back(mk(sia_pkg::CMD_SUB, 63'd5, TOP, 63'd1, 63'd3));     // unbounded minuend
        cases.push_back(mk(sia_pkg::CMD_SUB, 63'd7, 63'd7, 63'd7, 63'd7));       // equal bounds
        cases.push_back(mk(sia_pkg::CMD_SUB, 63'd3, 63'd9, 63'd2, TOP));  // unbounded subtrahend
        cases.push_back(mk(sia_pkg::CMD_SUB, 63'd1, '0, 63'd4, 63'd8));          // inverted left
        cases.push_back(mk(sia_pkg::CMD_MUL, '0, 63'd5, 63'd7, TOP));            // zero factor
        cases.push_back(mk(sia_pkg::CMD_MUL, 63'h1_0000_0000, 63'h1_0000_0000,
                           63'h8000_0000, 63'h8000_0000));                  // lands on 2^63
        cases.push_back(mk(sia_pkg::CMD_MUL, 63'h8000_0000, 63'h8000_0000,
                           63'h8000_0000, 63'h8000_0000));                  // 2^62 fits
        cases.push_back(mk(sia_pkg::CMD_MUL, 63'd3037000499, 63'd3037000500,
                           63'd3037000499, 63'd3037000500));                // square-root edge
        cases.push_back(mk(sia_pkg::CMD_MUL, 63'd2, 63'd3, 63'd9, 63'd4));       // inverted right
        cases.push_back(mk(sia_pkg::CMD_MUL, 63'd1, TOP, '0, '0));         // unbounded times zero
        cases.push_back(mk(sia_pkg::CMD_ISECT, 63'd2, 63'd10, 63'd5, 63'd20));
        cases.push_back(mk(sia_pkg::CMD_ISECT, 63'd2, 63'd3, 63'd5, 63'd9));     // disjoint
        cases.push_back(mk(sia_pkg::CMD_ISECT, TOP, TOP, TOP, TOP));             // both empty
        cases.push_back(mk(sia_pkg::CMD_ISECT, '0, TOP, 63'd4, 63'd4));          // nested point
        cases.push_back(mk(sia_pkg::CMD_ISECT, 63'd6, 63'd9, 63'd6, 63'd9));     // equal
        cases.push_back(mk(sia_pkg::CMD_ISECT, TOP, TOP, 63'd1, 63'd2));         // empty left
        foreach (cases[k]) begin
            idle_cycles($urandom_range(0, 2));
            send_item(cases[k]);
        end
    endtask

    task automatic test_random_mixed(input int n);
        repeat (n) begin
            idle_cycles(next_gap_length());
            send_item(random_item());
        end
    endtask

    // full rate: one item every cycle
    task automatic test_back_to_back(input int n);
        repeat (n) send_item(random_item());
    endtask

    // short random gaps, sized to land on each pipeline stage
    task automatic test_stage_gaps(input int n);
        repeat (n) begin
            idle_cycles($urandom_range(1, LATENCY + 2));
            send_item(random_item());
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin : main_sequence
        int waited;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_random_mixed(1300);
        test_back_to_back(300);
        test_stage_gaps(300);

        @(negedge i_clk);
        start = 1'b0;

        waited = 0;
        while (pending_results.size() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (pending_results.size() > 0) begin
            void'(pending_results.pop_front());
            report_mismatch("expected result never arrived", '0, '0);
        end

        $display("Sent %0d items (add %0d, sub %0d, mul %0d, intersect %0d), %s %0d results.",
                 items_sent, cmd_count[sia_pkg::CMD_ADD], cmd_count[sia_pkg::CMD_SUB],
                 cmd_count[sia_pkg::CMD_MUL], cmd_count[sia_pkg::CMD_ISECT], "checked",
                 results_checked);
        $display("Mismatches counted: %0d.", mismatch_count);
        if (mismatch_count == 0) begin
            $display("[saturating_interval_alu] OK");
        end else begin
            $display("[saturating_interval_alu] ERROR");
        end
        $finish;
    end

    // watchdog: far beyond the slowest correct run
    initial begin
        #1_500_000;
        $display("Timeout: run did not complete.");
        $display("[saturating_interval_alu] ERROR");
        $finish;
    end

endmodule

// File: files.f
rtl/sia_pkg.sv
rtl/sia_canon.sv
rtl/sia_mul.sv
rtl/saturating_interval_alu.sv
rtl/sia_check.sv
test/saturating_interval_alu_test.sv
